### sv/epfm_pkg.sv
`timescale 1ns / 1ps
// Package for the edge period frequency meter.
// Holds shared constants, the sequencer state type and the divider handshake types.
package epfm_pkg;

  localparam int unsigned DivWidth = 32;
  localparam int unsigned CntWidth = $clog2(DivWidth);
  localparam int unsigned FreqWidth = 20;
  localparam int unsigned TpmWidth = 10;

  localparam logic [DivWidth-1:0] MicrosPerSecond = 32'd1000000;
  localparam logic [TpmWidth-1:0] TpmReset = 10'd100;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV1 = 4'b0010,
    ST_DIV2 = 4'b0100,
    ST_OUT  = 4'b1000
  } seq_state_t;

  typedef struct packed {
    logic                start;
    logic [DivWidth-1:0] dividend;
    logic [DivWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [DivWidth-1:0] quotient;
  } div_rsp_t;

endpackage

### sv/epfm_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
// Depends on epfm_pkg for widths and request/response types.
module epfm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  epfm_pkg::div_req_t req,
  output epfm_pkg::div_rsp_t rsp
);

  logic [epfm_pkg::DivWidth-1:0] rem_r, rem_nxt;
  logic [epfm_pkg::DivWidth-1:0] quo_r, quo_nxt;
  logic [epfm_pkg::DivWidth-1:0] dvs_r, dvs_nxt;
  logic [epfm_pkg::CntWidth-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [epfm_pkg::DivWidth:0]   rem_sh;
  logic [epfm_pkg::DivWidth:0]   trial;

  assign rem_sh = {rem_r, quo_r[epfm_pkg::DivWidth-1]};
  assign trial  = rem_sh - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start && !busy_r) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[epfm_pkg::DivWidth]) begin
        rem_nxt = trial[epfm_pkg::DivWidth-1:0];
        quo_nxt = {quo_r[epfm_pkg::DivWidth-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[epfm_pkg::DivWidth-1:0];
        quo_nxt = {quo_r[epfm_pkg::DivWidth-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### sv/edge_period_frequency_meter_top.sv
`timescale 1ns / 1ps
// Top level: capture slots, measurement sequencer and result register.
// Depends on epfm_pkg and epfm_div.
//
// Each accepted edge transaction yields one result transaction. Processing goes
// through one shared 32-step restoring divider: the tick difference is divided by
// ticks_per_microsecond, and when the interval is nonzero and below one second,
// 1000000 is divided by the interval. For the first edge after reset the sequencer
// goes straight to the result register with no division; otherwise it runs the
// first division and, when a frequency is computed, the second. in_stall stays high
// until the result register is loaded, so no new edge is taken before the last one's
// result is in it. A stalled result register holds the sequencer until it frees.
// A zero timestamp is taken as 1; a zero divider setting acts as 1.
module edge_period_frequency_meter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_edge_timestamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_interval_us,
  output logic [19:0] out_frequency_hz,
  output logic        out_frequency_updated
);

  epfm_pkg::seq_state_t state_r, state_nxt;
  epfm_pkg::div_req_t   div_req;
  epfm_pkg::div_rsp_t   div_rsp;

  logic [epfm_pkg::TpmWidth-1:0]  tpm_r;
  logic                           slot_r, slot_nxt;
  logic                           have_prev_r, have_prev_nxt;
  logic [31:0]                    first_r, first_nxt;
  logic [31:0]                    second_r, second_nxt;
  logic [31:0]                    interval_r, interval_nxt;
  logic [epfm_pkg::FreqWidth-1:0] freq_r, freq_nxt;
  logic                           upd_r, upd_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [31:0]                    out_int_r, out_int_nxt;
  logic [epfm_pkg::FreqWidth-1:0] out_freq_r, out_freq_nxt;
  logic                           out_upd_r, out_upd_nxt;

  logic        in_acc;
  logic [31:0] now;
  logic [31:0] earlier;
  logic        measure;
  logic [31:0] tpm_eff;
  logic        out_free;
  logic        int_ok;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != epfm_pkg::ST_IDLE);
  assign now      = (in_edge_timestamp == 32'd0) ? 32'd1 : in_edge_timestamp;
  assign earlier  = slot_r ? first_r : second_r;
  assign measure  = slot_r || have_prev_r;
  assign tpm_eff  = (tpm_r == '0) ? 32'd1 : {22'd0, tpm_r};
  assign out_free = !out_valid_r || !out_stall;
  assign int_ok   = (div_rsp.quotient != 32'd0) &&
                    (div_rsp.quotient < epfm_pkg::MicrosPerSecond);

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    have_prev_nxt = have_prev_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    interval_nxt  = interval_r;
    freq_nxt      = freq_r;
    upd_nxt       = upd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_int_nxt   = out_int_r;
    out_freq_nxt  = out_freq_r;
    out_upd_nxt   = out_upd_r;
    div_req.start    = 1'b0;
    div_req.dividend = now - earlier;
    div_req.divisor  = tpm_eff;
    case (state_r)
      epfm_pkg::ST_IDLE: begin
        if (in_acc) begin
          upd_nxt = 1'b0;
          if (!slot_r) begin
            first_nxt     = now;
            have_prev_nxt = 1'b0;
            slot_nxt      = 1'b1;
          end else begin
            second_nxt    = now;
            have_prev_nxt = 1'b1;
            slot_nxt      = 1'b0;
          end
          if (measure) begin
            div_req.start = 1'b1;
            state_nxt     = epfm_pkg::ST_DIV1;
          end else begin
            state_nxt = epfm_pkg::ST_OUT;
          end
        end
      end
      epfm_pkg::ST_DIV1: begin
        div_req.dividend = epfm_pkg::MicrosPerSecond;
        div_req.divisor  = div_rsp.quotient;
        if (div_rsp.done) begin
          interval_nxt = div_rsp.quotient;
          if (int_ok) begin
            div_req.start = 1'b1;
            upd_nxt       = 1'b1;
            state_nxt     = epfm_pkg::ST_DIV2;
          end else begin
            state_nxt = epfm_pkg::ST_OUT;
          end
        end
      end
      epfm_pkg::ST_DIV2: begin
        if (div_rsp.done) begin
          freq_nxt  = div_rsp.quotient[epfm_pkg::FreqWidth-1:0];
          state_nxt = epfm_pkg::ST_OUT;
        end
      end
      epfm_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_int_nxt   = interval_r;
          out_freq_nxt  = freq_r;
          out_upd_nxt   = upd_r;
          state_nxt     = epfm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = epfm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= epfm_pkg::ST_IDLE;
      tpm_r       <= epfm_pkg::TpmReset;
      slot_r      <= 1'b0;
      have_prev_r <= 1'b0;
      first_r     <= '0;
      second_r    <= '0;
      interval_r  <= '0;
      freq_r      <= '0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        tpm_r <= cfg_wr_data;
      end
      slot_r      <= slot_nxt;
      have_prev_r <= have_prev_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      interval_r  <= interval_nxt;
      freq_r      <= freq_nxt;
      upd_r       <= upd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_int_r  <= out_int_nxt;
    out_freq_r <= out_freq_nxt;
    out_upd_r  <= out_upd_nxt;
  end

  epfm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid             = out_valid_r;
  assign out_interval_us       = out_int_r;
  assign out_frequency_hz      = out_freq_r;
  assign out_frequency_updated = out_upd_r;

endmodule
